@@ rtl/i2cm_pkg.sv @@
// i2cm_pkg: shared types and constants of the I2C master bit engine.
// Self-contained; used by scoped name in every rtl file.

package i2cm_pkg;

  localparam int PHASE_W     = 16;
  localparam int TIMEOUT_W   = 8;
  localparam int BYTE_W      = 8;
  localparam int BIT_IDX_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd100;
  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE   = 4'd8;

  // Configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_START_A  = 4'd1,
    ST_START_B  = 4'd2,
    ST_STOP_A   = 4'd3,
    ST_STOP_B   = 4'd4,
    ST_WR_LOW   = 4'd5,
    ST_WR_HIGH  = 4'd6,
    ST_RD_LOW   = 4'd7,
    ST_RD_HIGH  = 4'd8,
    ST_ACK_LOW  = 4'd9,
    ST_ACK_HIGH = 4'd10,
    ST_WA_SETUP = 4'd11,
    ST_WA_HIGH  = 4'd12,
    ST_WA_POLL  = 4'd13
  } state_t;

  typedef struct packed {
    logic              sda_in;
    logic              send_ack;
    logic [BYTE_W-1:0] tx_byte;
    logic [2:0]        command;
  } item_t;

  typedef struct packed {
    logic              ack_failed;
    logic [BYTE_W-1:0] rx_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_drive;
    logic              sda_level;
    logic              scl_level;
  } result_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_ticks;
    logic [TIMEOUT_W-1:0] ack_timeout;
  } cfg_t;

endpackage

@@ rtl/i2cm_core.sv @@
// i2cm_core: bus sequencer of the I2C master bit engine; one tick per step.
// Depends on i2cm_pkg.

module i2cm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  i2cm_pkg::item_t    item,
  input  i2cm_pkg::cfg_t     cfg,
  output i2cm_pkg::result_t  res
);

  i2cm_pkg::state_t                    state_r, state_nxt;
  logic [i2cm_pkg::PHASE_W-1:0]        pc_r, pc_nxt;
  logic [i2cm_pkg::BIT_IDX_W-1:0]      bit_r, bit_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]         shift_r, shift_nxt;
  logic [i2cm_pkg::TIMEOUT_W-1:0]      wait_r, wait_nxt;
  logic                                scl_r, scl_nxt;
  logic                                sda_r, sda_nxt;
  logic                                drive_r, drive_nxt;
  logic                                ack_flag_r, ack_flag_nxt;
  logic                                ack_choice_r, ack_choice_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]         rx_r, rx_nxt;
  logic                                done_c;

  logic [i2cm_pkg::PHASE_W-1:0]        limit;
  logic [i2cm_pkg::PHASE_W:0]          pc_inc;
  logic                                expire;
  logic [i2cm_pkg::BIT_IDX_W-1:0]      bit_inc;
  logic                                last_bit;
  logic                                timed_out;

  // A zero phase length behaves as one tick
  assign limit     = (cfg.phase_ticks == '0) ? {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1}
                                             : cfg.phase_ticks;
  assign pc_inc    = {1'b0, pc_r} + {{i2cm_pkg::PHASE_W{1'b0}}, 1'b1};
  assign expire    = pc_inc >= {1'b0, limit};
  assign bit_inc   = bit_r + {{(i2cm_pkg::BIT_IDX_W-1){1'b0}}, 1'b1};
  assign last_bit  = bit_inc >= i2cm_pkg::BITS_PER_BYTE;
  assign timed_out = wait_r >= cfg.ack_timeout;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      i2cm_pkg::ST_IDLE: begin
        case (item.command)
          i2cm_pkg::CMD_START:    state_nxt = i2cm_pkg::ST_START_A;
          i2cm_pkg::CMD_STOP:     state_nxt = i2cm_pkg::ST_STOP_A;
          i2cm_pkg::CMD_WRITE:    state_nxt = i2cm_pkg::ST_WR_LOW;
          i2cm_pkg::CMD_READ:     state_nxt = i2cm_pkg::ST_RD_LOW;
          i2cm_pkg::CMD_WAIT_ACK: state_nxt = i2cm_pkg::ST_WA_SETUP;
          default:                state_nxt = i2cm_pkg::ST_IDLE;
        endcase
      end
      i2cm_pkg::ST_WA_POLL: begin
        if (!item.sda_in) state_nxt = i2cm_pkg::ST_IDLE;
        else if (timed_out) state_nxt = i2cm_pkg::ST_STOP_A;
      end
      i2cm_pkg::ST_START_A:  if (expire) state_nxt = i2cm_pkg::ST_START_B;
      i2cm_pkg::ST_START_B:  if (expire) state_nxt = i2cm_pkg::ST_IDLE;
      i2cm_pkg::ST_STOP_A:   if (expire) state_nxt = i2cm_pkg::ST_STOP_B;
      i2cm_pkg::ST_STOP_B:   if (expire) state_nxt = i2cm_pkg::ST_IDLE;
      i2cm_pkg::ST_WR_LOW:   if (expire) state_nxt = i2cm_pkg::ST_WR_HIGH;
      i2cm_pkg::ST_WR_HIGH: begin
        if (expire) state_nxt = last_bit ? i2cm_pkg::ST_IDLE : i2cm_pkg::ST_WR_LOW;
      end
      i2cm_pkg::ST_RD_LOW:   if (expire) state_nxt = i2cm_pkg::ST_RD_HIGH;
      i2cm_pkg::ST_RD_HIGH: begin
        if (expire) state_nxt = last_bit ? i2cm_pkg::ST_ACK_LOW : i2cm_pkg::ST_RD_LOW;
      end
      i2cm_pkg::ST_ACK_LOW:  if (expire) state_nxt = i2cm_pkg::ST_ACK_HIGH;
      i2cm_pkg::ST_ACK_HIGH: if (expire) state_nxt = i2cm_pkg::ST_IDLE;
      i2cm_pkg::ST_WA_SETUP: if (expire) state_nxt = i2cm_pkg::ST_WA_HIGH;
      i2cm_pkg::ST_WA_HIGH:  if (expire) state_nxt = i2cm_pkg::ST_WA_POLL;
      default:               state_nxt = i2cm_pkg::ST_IDLE;
    endcase
  end

  // Bus levels, counters and shifter
  always_comb begin
    pc_nxt         = pc_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    wait_nxt       = wait_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    drive_nxt      = drive_r;
    ack_flag_nxt   = ack_flag_r;
    ack_choice_nxt = ack_choice_r;
    rx_nxt         = rx_r;
    done_c         = 1'b0;
    unique case (state_r)
      i2cm_pkg::ST_IDLE: begin
        pc_nxt = '0;
        case (item.command)
          i2cm_pkg::CMD_START: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            drive_nxt = 1'b1;
          end
          i2cm_pkg::CMD_STOP: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            drive_nxt = 1'b1;
          end
          i2cm_pkg::CMD_WRITE: begin
            scl_nxt   = 1'b0;
            drive_nxt = 1'b1;
            sda_nxt   = item.tx_byte[i2cm_pkg::BYTE_W-1];
            shift_nxt = {item.tx_byte[i2cm_pkg::BYTE_W-2:0], 1'b0};
            bit_nxt   = '0;
          end
          i2cm_pkg::CMD_READ: begin
            scl_nxt        = 1'b0;
            sda_nxt        = 1'b1;
            drive_nxt      = 1'b0;
            shift_nxt      = '0;
            bit_nxt        = '0;
            ack_choice_nxt = item.send_ack;
          end
          i2cm_pkg::CMD_WAIT_ACK: begin
            sda_nxt      = 1'b1;
            drive_nxt    = 1'b0;
            ack_flag_nxt = 1'b0;
            wait_nxt     = '0;
          end
          default: ;
        endcase
      end
      i2cm_pkg::ST_WA_POLL: begin
        if (!item.sda_in) begin
          scl_nxt = 1'b0;
          done_c  = 1'b1;
        end else if (timed_out) begin
          // Give up on the slave: flag it and release the bus with a stop
          ack_flag_nxt = 1'b1;
          pc_nxt       = '0;
          scl_nxt      = 1'b0;
          sda_nxt      = 1'b0;
          drive_nxt    = 1'b1;
        end else begin
          wait_nxt = wait_r + {{(i2cm_pkg::TIMEOUT_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        pc_nxt = expire ? '0 : pc_inc[i2cm_pkg::PHASE_W-1:0];
        if (expire) begin
          case (state_r)
            i2cm_pkg::ST_START_A: sda_nxt = 1'b0;
            i2cm_pkg::ST_START_B: begin
              scl_nxt = 1'b0;
              done_c  = 1'b1;
            end
            i2cm_pkg::ST_STOP_A:  scl_nxt = 1'b1;
            i2cm_pkg::ST_STOP_B: begin
              sda_nxt = 1'b1;
              done_c  = 1'b1;
            end
            i2cm_pkg::ST_WR_LOW:  scl_nxt = 1'b1;
            i2cm_pkg::ST_WR_HIGH: begin
              scl_nxt = 1'b0;
              bit_nxt = bit_inc;
              if (last_bit) begin
                done_c = 1'b1;
              end else begin
                sda_nxt   = shift_r[i2cm_pkg::BYTE_W-1];
                shift_nxt = {shift_r[i2cm_pkg::BYTE_W-2:0], 1'b0};
              end
            end
            i2cm_pkg::ST_RD_LOW: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[i2cm_pkg::BYTE_W-2:0], item.sda_in};
            end
            i2cm_pkg::ST_RD_HIGH: begin
              scl_nxt = 1'b0;
              bit_nxt = bit_inc;
              if (last_bit) begin
                rx_nxt    = shift_r;
                sda_nxt   = !ack_choice_r;
                drive_nxt = 1'b1;
              end
            end
            i2cm_pkg::ST_ACK_LOW:  scl_nxt = 1'b1;
            i2cm_pkg::ST_ACK_HIGH: begin
              scl_nxt = 1'b0;
              done_c  = 1'b1;
            end
            i2cm_pkg::ST_WA_SETUP: scl_nxt = 1'b1;
            default: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= i2cm_pkg::ST_IDLE;
      pc_r         <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      wait_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      drive_r      <= 1'b1;
      ack_flag_r   <= 1'b0;
      ack_choice_r <= 1'b0;
      rx_r         <= '0;
    end else if (step) begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      wait_r       <= wait_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      drive_r      <= drive_nxt;
      ack_flag_r   <= ack_flag_nxt;
      ack_choice_r <= ack_choice_nxt;
      rx_r         <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.sda_drive  = drive_nxt;
    res.busy_res   = state_nxt != i2cm_pkg::ST_IDLE;
    res.done_res   = done_c;
    res.rx_byte    = rx_nxt;
    res.ack_failed = ack_flag_nxt;
  end

endmodule

@@ rtl/i2c_master_bit_engine.sv @@
// i2c_master_bit_engine: top level of the I2C master bit engine.
// Depends on i2cm_pkg and i2cm_core.
//
//  channel  | ports                       | beat
//  ---------+-----------------------------+----------------------------------------
//  in       | in_tvalid/in_tready/in_tdata| one tick: command, tx byte, ack, SDA
//  out      | out_tvalid/out_tready/...   | bus levels and status after that tick
//  cfg      | cfg_we/cfg_index/cfg_data   | register write, no read-back
//
// Every input beat yields exactly one output beat: the input register holds the
// tick, then the output register holds its result. The sequencer state updates
// on each advance, so a beat can be taken every cycle while the output side is
// not stalled; the input register and the output register are the two stages.
// A stalled output holds its beat and backs up into the input register, then
// in_tready drops. Reset (synchronous, rst_n low) releases the bus (SCL and SDA
// high), empties both stages and loads the register defaults.

module i2c_master_bit_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  // {sda_in[12], send_ack[11], tx_byte[10:3], command[2:0]}, upper bits zero
  input  logic [i2cm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // {ack_failed[13], rx_byte[12:5], done_res[4], busy_res[3], sda_drive[2],
  //  sda_level[1], scl_level[0]}, upper bits zero
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ItemW = $bits(i2cm_pkg::item_t);
  localparam int ResW  = $bits(i2cm_pkg::result_t);

  logic                 in_v_r;
  i2cm_pkg::item_t      item_r;
  logic                 out_v_r;
  i2cm_pkg::result_t    res_r;
  i2cm_pkg::result_t    res_c;
  i2cm_pkg::cfg_t       cfg_r;
  logic                 adv;

  // Advance the held tick into the sequencer when the output slot frees up
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= i2cm_pkg::item_t'(in_tdata[ItemW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_c;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
      cfg_r.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_PHASE_TICKS: cfg_r.phase_ticks <= cfg_data;
        i2cm_pkg::CFG_ACK_TIMEOUT:
          cfg_r.ack_timeout <= cfg_data[i2cm_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  i2cm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res_c)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(i2cm_pkg::OUT_TDATA_W-ResW){1'b0}}, res_r};

endmodule

@@ rtl/i2cm_checker.sv @@
// i2cm_checker: port-level assertions for the I2C master bit engine, bound to the top.
// Depends on i2cm_pkg for widths only.

module i2cm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic [i2cm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // A held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // The finishing tick already reports the engine as free
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[3]))
    else $error("done and busy in the same beat");

  // When SDA is not driven it must read as released
  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[1])
    else $error("SDA low while not driven");

  // Reset empties the output stage and the input stage
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("stages not empty after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for the I2C master bit engine. Each input beat is one
// SDA tick; an in-house model predicts each output beat and the beats are
// compared field by field. Depends on i2cm_pkg and i2c_master_bit_engine only.

module tb;
  import i2cm_pkg::*;

  // Command codes the engine must ignore
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int IDLE_PCT        = 19;    // chance of a gap on either side
  localparam int HOLD_OFF_CYCLES = 400;   // one long output stall
  localparam int QUIET_LIMIT     = 4000;  // cycles without any beat before giving up
  localparam int RANDOM_TICKS    = 240;   // busy or accepting ticks in the random part
  localparam int RANDOM_PHASES   = 6;

  // How SDA behaves while a command runs
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_NOISY, SDA_STUCK} sda_mode_t;

  typedef struct {
    bit                    is_cfg;
    logic                  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [2:0]            cmd;
    logic [BYTE_W-1:0]     tx;
    logic                  ack;
    sda_mode_t             sda_mode;
    logic [2:0]            busy_cmd;   // offered on every tick while the command runs
    bit                    has_want;
    result_t               want;
  } step_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  // {sda_in[12], send_ack[11], tx_byte[10:3], command[2:0]}, upper bits zero
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // {ack_failed[13], rx_byte[12:5], done_res[4], busy_res[3], sda_drive[2],
  //  sda_level[1], scl_level[0]}, upper bits zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  always #5 clk = ~clk;

  i2c_master_bit_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Engine model: our own copy of registers and sequencer state
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]   phase_ticks_q;
  logic [TIMEOUT_W-1:0] ack_timeout_q;
  state_t               seq_st;
  logic [PHASE_W-1:0]   phase_cnt;
  logic [BIT_IDX_W-1:0] bit_cnt;
  logic [BYTE_W-1:0]    shift_q;
  logic [TIMEOUT_W-1:0] poll_cnt;
  logic                 scl_q, sda_q, drive_q, ack_fail_q, ack_choice_q;
  logic [BYTE_W-1:0]    rx_q;

  result_t bus_levels_q[$];   // predicted output beats, oldest first

  int  mismatches     = 0;
  int  beats_checked  = 0;
  int  ticks_sent     = 0;
  int  live_ticks     = 0;    // ticks that start a command or advance one
  int  ack_timeouts   = 0;
  int  cmd_seen[8];
  bit  calm           = 1'b0; // no gaps on either side while set
  int  hold_asks      = 0;    // bump to make the output side stall for a long stretch
  int  quiet_cycles   = 0;

  task automatic reset_model();
    phase_ticks_q = PHASE_TICKS_RST;
    ack_timeout_q = ACK_TIMEOUT_RST;
    seq_st        = ST_IDLE;
    phase_cnt     = '0;
    bit_cnt       = '0;
    shift_q       = '0;
    poll_cnt      = '0;
    scl_q         = 1'b1;
    sda_q         = 1'b1;
    drive_q       = 1'b1;
    ack_fail_q    = 1'b0;
    ack_choice_q  = 1'b0;
    rx_q          = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
  endtask

  function automatic void begin_stop();
    scl_q   = 1'b0;
    sda_q   = 1'b0;
    drive_q = 1'b1;
    seq_st  = ST_STOP_A;
  endfunction

  // Advance the model by one tick and return the levels it shows afterwards.
  function automatic result_t engine_tick(input item_t it);
    logic               finished;
    logic [PHASE_W-1:0] limit;
    result_t            r;
    finished = 1'b0;
    limit    = phase_ticks_q;
    if (limit == '0) limit = PHASE_W'(1);   // zero length behaves as one tick

    if (seq_st == ST_IDLE) begin
      // Only an idle engine takes a command
      phase_cnt = '0;
      case (it.command)
        CMD_START: begin
          scl_q = 1'b1; sda_q = 1'b1; drive_q = 1'b1;
          seq_st = ST_START_A;
        end
        CMD_STOP: begin_stop();
        CMD_WRITE: begin
          scl_q   = 1'b0; drive_q = 1'b1;
          sda_q   = it.tx_byte[7];
          shift_q = {it.tx_byte[6:0], 1'b0};
          bit_cnt = '0;
          seq_st  = ST_WR_LOW;
        end
        CMD_READ: begin
          scl_q = 1'b0; sda_q = 1'b1; drive_q = 1'b0;
          shift_q      = '0;
          bit_cnt      = '0;
          ack_choice_q = it.send_ack;
          seq_st       = ST_RD_LOW;
        end
        CMD_WAIT_ACK: begin
          sda_q = 1'b1; drive_q = 1'b0;
          ack_fail_q = 1'b0;
          poll_cnt   = '0;
          seq_st     = ST_WA_SETUP;
        end
        default: ;
      endcase
    end else if (seq_st == ST_WA_POLL) begin
      // Poll SDA once per tick: low is the ACK, too many highs give up and stop
      if (!it.sda_in) begin
        scl_q    = 1'b0;
        seq_st   = ST_IDLE;
        finished = 1'b1;
      end else if (poll_cnt >= ack_timeout_q) begin
        ack_fail_q = 1'b1;
        phase_cnt  = '0;
        ack_timeouts++;
        begin_stop();
      end else begin
        poll_cnt = poll_cnt + 1'b1;
      end
    end else begin
      phase_cnt = phase_cnt + 1'b1;
      if (phase_cnt >= limit) begin
        phase_cnt = '0;
        case (seq_st)
          ST_START_A: begin sda_q = 1'b0; seq_st = ST_START_B; end
          ST_START_B: begin scl_q = 1'b0; seq_st = ST_IDLE; finished = 1'b1; end
          ST_STOP_A:  begin scl_q = 1'b1; seq_st = ST_STOP_B; end
          ST_STOP_B:  begin sda_q = 1'b1; seq_st = ST_IDLE; finished = 1'b1; end
          ST_WR_LOW:  begin scl_q = 1'b1; seq_st = ST_WR_HIGH; end
          ST_WR_HIGH: begin
            scl_q   = 1'b0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              seq_st   = ST_IDLE;
              finished = 1'b1;
            end else begin
              sda_q   = shift_q[7];
              shift_q = {shift_q[6:0], 1'b0};
              seq_st  = ST_WR_LOW;
            end
          end
          ST_RD_LOW: begin
            // Sample SDA on the rising SCL edge
            scl_q   = 1'b1;
            shift_q = {shift_q[6:0], it.sda_in};
            seq_st  = ST_RD_HIGH;
          end
          ST_RD_HIGH: begin
            scl_q   = 1'b0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              rx_q    = shift_q;
              sda_q   = ~ack_choice_q;   // ACK pulls low, NACK leaves high
              drive_q = 1'b1;
              seq_st  = ST_ACK_LOW;
            end else begin
              seq_st = ST_RD_LOW;
            end
          end
          ST_ACK_LOW:  begin scl_q = 1'b1; seq_st = ST_ACK_HIGH; end
          ST_ACK_HIGH: begin scl_q = 1'b0; seq_st = ST_IDLE; finished = 1'b1; end
          ST_WA_SETUP: begin scl_q = 1'b1; seq_st = ST_WA_HIGH; end
          ST_WA_HIGH:  seq_st = ST_WA_POLL;
          default:     seq_st = ST_IDLE;
        endcase
      end
    end

    r.scl_level  = scl_q;
    r.sda_level  = sda_q;
    r.sda_drive  = drive_q;
    r.busy_res   = (seq_st != ST_IDLE);
    r.done_res   = finished;
    r.rx_byte    = rx_q;
    r.ack_failed = ack_fail_q;
    return r;
  endfunction

  function automatic result_t make_levels(input logic scl, input logic sda,
                                          input logic drive, input logic busy,
                                          input logic done, input logic [BYTE_W-1:0] rx,
                                          input logic failed);
    result_t r;
    r.scl_level  = scl;
    r.sda_level  = sda;
    r.sda_drive  = drive;
    r.busy_res   = busy;
    r.done_res   = done;
    r.rx_byte    = rx;
    r.ack_failed = failed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_LOW:   return 1'b0;
      SDA_HIGH:  return 1'b1;
      SDA_STUCK: return ($urandom_range(19) != 0);   // rare low
      default:   return 1'($urandom_range(1));
    endcase
  endfunction

  // Mostly no command while busy; sometimes any code, which must be ignored
  function automatic logic [2:0] pick_busy_cmd();
    if ($urandom_range(3) == 0) return 3'($urandom_range(7));
    return CMD_NONE;
  endfunction

  function automatic sda_mode_t pick_ack_mode();
    int r;
    r = $urandom_range(9);
    if (r == 0) return SDA_HIGH;
    if (r < 3)  return SDA_STUCK;
    return SDA_NOISY;
  endfunction

  // Offer one tick, wait for the handshake, then log what the engine should show.
  task automatic send_tick(input item_t it, input bit has_want, input result_t want);
    result_t r;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata  <= {3'b000, it.sda_in, it.send_ack, it.tx_byte, it.command};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (seq_st != ST_IDLE ||
        it.command inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT_ACK})
      live_ticks++;
    if (seq_st == ST_IDLE) cmd_seen[it.command]++;
    r = engine_tick(it);
    bus_levels_q.push_back(has_want ? want : r);
    ticks_sent++;
  endtask

  // Issue a command and keep ticking until the engine is idle again.
  task automatic run_cmd(input logic [2:0] cmd, input logic [BYTE_W-1:0] tx,
                         input logic ack, input sda_mode_t mode,
                         input logic [2:0] busy_cmd,
                         input bit has_want = 1'b0, input result_t want = '0);
    item_t it;
    it.command  = cmd;
    it.tx_byte  = tx;
    it.send_ack = ack;
    it.sda_in   = pick_sda(mode);
    send_tick(it, has_want, want);
    while (seq_st != ST_IDLE) begin
      it.command  = busy_cmd;
      it.tx_byte  = 8'($urandom_range(255));
      it.send_ack = 1'($urandom_range(1));
      it.sda_in   = pick_sda(mode);
      send_tick(it, 1'b0, '0);
    end
  endtask

  // Stop offering and wait for every predicted beat to come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PHASE_TICKS) phase_ticks_q = val;
    else                        ack_timeout_q = val[TIMEOUT_W-1:0];
    @(posedge clk);
  endtask

  // One bus transfer: start, address, ACK, up to three data bytes, stop. A tenth
  // of them are marked broken and may lose the start or the stop.
  task automatic run_transfer();
    int ops;
    bit broken;
    broken = ($urandom_range(9) == 0);
    if (!broken || $urandom_range(1))
      run_cmd(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISY,
              pick_busy_cmd());
    run_cmd(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISY,
            pick_busy_cmd());
    run_cmd(CMD_WAIT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), pick_ack_mode(),
            pick_busy_cmd());
    ops = $urandom_range(3);
    // A timed-out ACK already ran the stop sequence, so abandon the transfer
    for (int k = 0; k < ops && !ack_fail_q; k++) begin
      if ($urandom_range(1)) begin
        run_cmd(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISY,
                pick_busy_cmd());
        run_cmd(CMD_WAIT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                pick_ack_mode(), pick_busy_cmd());
      end else begin
        // NACK the last byte read, as a master does
        run_cmd(CMD_READ, 8'($urandom_range(255)),
                (k == ops - 1) ? 1'b0 : 1'($urandom_range(1)),
                SDA_NOISY, pick_busy_cmd());
      end
    end
    if (!ack_fail_q && !(broken && $urandom_range(1)))
      run_cmd(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISY,
              pick_busy_cmd());
  endtask

  function automatic step_row_t tick_row(input logic [2:0] cmd, input logic [BYTE_W-1:0] tx,
                                         input logic ack, input sda_mode_t mode,
                                         input logic [2:0] busy_cmd,
                                         input bit has_want = 1'b0,
                                         input result_t want = '0);
    step_row_t s;
    s.is_cfg   = 1'b0;
    s.reg_idx  = CFG_PHASE_TICKS;
    s.reg_val  = '0;
    s.cmd      = cmd;
    s.tx       = tx;
    s.ack      = ack;
    s.sda_mode = mode;
    s.busy_cmd = busy_cmd;
    s.has_want = has_want;
    s.want     = want;
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic idx, input logic [CFG_DATA_W-1:0] val);
    step_row_t s;
    s         = tick_row(CMD_NONE, '0, 1'b0, SDA_HIGH, CMD_NONE);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, one long hold-off, and the beat check
  // ---------------------------------------------------------------------------
  task automatic check_beat();
    result_t got;
    result_t want;
    got = result_t'(out_tdata[$bits(result_t)-1:0]);
    beats_checked++;
    if (bus_levels_q.size() == 0) begin
      $error("output beat %h with no prediction pending", out_tdata);
      mismatches++;
    end else begin
      want = bus_levels_q.pop_front();
      if (got.scl_level !== want.scl_level) begin
        $error("scl_level: expected %0d, got %0d", want.scl_level, got.scl_level);
        mismatches++;
      end
      if (got.sda_level !== want.sda_level) begin
        $error("sda_level: expected %0d, got %0d", want.sda_level, got.sda_level);
        mismatches++;
      end
      if (got.sda_drive !== want.sda_drive) begin
        $error("sda_drive: expected %0d, got %0d", want.sda_drive, got.sda_drive);
        mismatches++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        mismatches++;
      end
      if (got.rx_byte !== want.rx_byte) begin
        $error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
        mismatches++;
      end
      if (got.ack_failed !== want.ack_failed) begin
        $error("ack_failed: expected %0d, got %0d", want.ack_failed, got.ack_failed);
        mismatches++;
      end
    end
  endtask

  initial begin
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_beat();
      // Count the long stall here so the sender keeps pushing meanwhile
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d predictions pending",
               quiet_cycles, bus_levels_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    step_row_t   rows[$];
    int          target;
    int unsigned phase_set[RANDOM_PHASES];
    int unsigned wait_set[RANDOM_PHASES];

    phase_set = '{1, 2, 0, 3, 1, 5};
    wait_set  = '{3, 1, 0, 20, 255, 2};

    reset_model();

    // Directed rows. Typed levels only on the reset tick and the first start.
    rows.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, SDA_HIGH, CMD_NONE, 1'b1,
                            make_levels(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)));
    rows.push_back(cfg_row(CFG_PHASE_TICKS, 16'd1));
    // Start with a stop offered on every busy tick, including the done tick
    rows.push_back(tick_row(CMD_START, 8'hFF, 1'b1, SDA_HIGH, CMD_STOP, 1'b1,
                            make_levels(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)));
    rows.push_back(tick_row(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, CMD_START));
    rows.push_back(tick_row(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, CMD_WRITE));
    rows.push_back(tick_row(CMD_WRITE, 8'h80, 1'b0, SDA_NOISY, CMD_NONE));
    rows.push_back(tick_row(CMD_READ, 8'h00, 1'b1, SDA_HIGH, CMD_READ));      // 0xFF, ACK
    rows.push_back(tick_row(CMD_READ, 8'hFF, 1'b0, SDA_LOW, CMD_NONE));       // 0x00, NACK
    rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_LOW, CMD_WAIT_ACK)); // acked
    rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, CMD_NONE));  // default timeout
    rows.push_back(cfg_row(CFG_ACK_TIMEOUT, 16'd0));                         // first high fails
    rows.push_back(tick_row(CMD_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH, CMD_SPARE_6));
    rows.push_back(cfg_row(CFG_PHASE_TICKS, 16'd0));                         // acts as one
    rows.push_back(tick_row(CMD_START, 8'h5A, 1'b0, SDA_NOISY, CMD_SPARE_7));
    rows.push_back(tick_row(CMD_READ, 8'hA5, 1'b1, SDA_NOISY, CMD_SPARE_6));
    rows.push_back(tick_row(CMD_STOP, 8'h00, 1'b0, SDA_NOISY, CMD_NONE));
    rows.push_back(tick_row(CMD_SPARE_6, 8'hFF, 1'b1, SDA_HIGH, CMD_NONE));  // ignored at idle
    rows.push_back(tick_row(CMD_SPARE_7, 8'h00, 1'b0, SDA_LOW, CMD_NONE));
    rows.push_back(cfg_row(CFG_ACK_TIMEOUT, 16'd255));
    rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, CMD_NONE)); // longest poll
    rows.push_back(cfg_row(CFG_PHASE_TICKS, 16'd20));                       // long phase
    rows.push_back(tick_row(CMD_START, 8'h00, 1'b0, SDA_NOISY, CMD_NONE));
    rows.push_back(cfg_row(CFG_PHASE_TICKS, 16'd2));
    rows.push_back(tick_row(CMD_WRITE, 8'hA5, 1'b1, SDA_NOISY, CMD_WRITE));
    rows.push_back(tick_row(CMD_STOP, 8'h3C, 1'b1, SDA_NOISY, CMD_READ));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Register writes only go in with nothing in flight and the sequencer idle
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        run_cmd(rows[i].cmd, rows[i].tx, rows[i].ack, rows[i].sda_mode,
                rows[i].busy_cmd, rows[i].has_want, rows[i].want);
      end
    end

    // Random transfers under several register settings. Phase 1 runs with no
    // gaps at all; phase 2 opens with a long output stall to back up the input.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_reg(CFG_PHASE_TICKS, CFG_DATA_W'(phase_set[p]));
      write_reg(CFG_ACK_TIMEOUT, CFG_DATA_W'(wait_set[p]));
      calm = (p == 1);
      if (p == 2) hold_asks++;
      target = live_ticks + RANDOM_TICKS / RANDOM_PHASES;
      while (live_ticks < target) begin
        if ($urandom_range(4) == 0)
          run_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_NOISY, pick_busy_cmd());
        else
          run_transfer();
      end
    end
    calm = 1'b0;

    // Drain, then keep watching for any stray beat to show up
    in_tvalid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run: %0d ticks (%0d advancing the engine), %0d beats checked, %0d ACK timeouts.",
             ticks_sent, live_ticks, beats_checked, ack_timeouts);
    $display("Taken at idle: %0d start, %0d stop, %0d write, %0d read, %0d wait-ack, %0d other.",
             cmd_seen[CMD_START], cmd_seen[CMD_STOP], cmd_seen[CMD_WRITE],
             cmd_seen[CMD_READ], cmd_seen[CMD_WAIT_ACK],
             cmd_seen[CMD_NONE] + cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7]);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
